>>> rtl/core/cpc_pkg.sv
// Shared constants, control struct and arctangent table for the polar/cartesian converter.
// Used by every module under rtl/core; no dependencies of its own.
`default_nettype none

package cpc_pkg;

    // default parameter values
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // fixed-point formats
    localparam int GUARD_BITS  = 8;
    localparam int ANGLE_SHIFT = 9;
    localparam int GAIN_SHIFT  = 16;
    localparam int GAIN_Q16    = 39797;
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_W      = 22;

    // angle limits in input units (degrees times 128)
    localparam int DEG90_IN  = 11520;
    localparam int DEG180_IN = 23040;
    localparam int DEG360_IN = 46080;

    // opcodes
    localparam logic OP_TO_POLAR = 1'b0;
    localparam logic OP_TO_RECT  = 1'b1;

    // per-item control carried along the chain
    typedef struct packed {
        logic rot;     // rotation mode (polar to cartesian)
        logic origin;  // vectoring input at the origin, angle forced to zero
    } cpc_ctl_t;

    // atan(2^-i) in degrees times 2^16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
        logic [ATAN_W-1:0] v;
        begin
            case (idx)
                0:       v = 22'd2949120;
                1:       v = 22'd1740967;
                2:       v = 22'd919879;
                3:       v = 22'd466945;
                4:       v = 22'd234379;
                5:       v = 22'd117304;
                6:       v = 22'd58666;
                7:       v = 22'd29335;
                8:       v = 22'd14668;
                9:       v = 22'd7334;
                10:      v = 22'd3667;
                11:      v = 22'd1833;
                12:      v = 22'd917;
                13:      v = 22'd458;
                14:      v = 22'd229;
                15:      v = 22'd115;
                16:      v = 22'd57;
                17:      v = 22'd29;
                18:      v = 22'd14;
                19:      v = 22'd7;
                20:      v = 22'd4;
                21:      v = 22'd2;
                22:      v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/cartesian_polar_converter.sv
// Cartesian/polar converter: unrolled CORDIC as a chain of micro-rotation cells.
// Pipeline: input stage, one cell per iteration capped at 24, multiply stage, output
// register. Throughput: one transfer per cycle unless m_axis_tready back-pressures;
// every stage has its own valid and refills bubbles.
// Reset: synchronous active-low aresetn clears all stage valids; data is not reset.
// Depends on cpc_pkg, cpc_prep, cpc_cell and cpc_post.
`default_nettype none

module cartesian_polar_converter #(
    parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF,
    parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // coord_a, coord_b
    input  wire  [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  wire                              s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // result_a, result_b, zero fill
    output logic [((2*DATA_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

    localparam int N      = (ITERATIONS > cpc_pkg::ATAN_LEN) ? cpc_pkg::ATAN_LEN : ITERATIONS;
    localparam int XW     = DATA_WIDTH + 10;
    localparam int ZW     = (DATA_WIDTH + 12 > 28) ? DATA_WIDTH + 12 : 28;
    localparam int OUT_TW = ((2*DATA_WIDTH+8)/8)*8;

    logic                           valid_c [0:N];
    logic                           ready_c [0:N];
    logic signed [XW-1:0]           x_c     [0:N];
    logic signed [XW-1:0]           y_c     [0:N];
    logic signed [ZW-1:0]           z_c     [0:N];
    cpc_pkg::cpc_ctl_t              ctl_c   [0:N];

    logic signed [DATA_WIDTH:0]     result_a;
    logic signed [DATA_WIDTH-1:0]   result_b;

    // input conditioning
    cpc_prep #(
        .DW (DATA_WIDTH),
        .XW (XW),
        .ZW (ZW)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (s_axis_tuser),
        .coord_a   (s_axis_tdata[DATA_WIDTH-1:0]),
        .coord_b   (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .x_out     (x_c[0]),
        .y_out     (y_c[0]),
        .z_out     (z_c[0]),
        .ctl_out   (ctl_c[0])
    );

    // micro-rotation chain
    for (genvar k = 0; k < N; k++) begin : g_cell
        cpc_cell #(
            .XW  (XW),
            .ZW  (ZW),
            .IDX (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_c[k]),
            .in_ready  (ready_c[k]),
            .x_in      (x_c[k]),
            .y_in      (y_c[k]),
            .z_in      (z_c[k]),
            .ctl_in    (ctl_c[k]),
            .out_valid (valid_c[k+1]),
            .out_ready (ready_c[k+1]),
            .x_out     (x_c[k+1]),
            .y_out     (y_c[k+1]),
            .z_out     (z_c[k+1]),
            .ctl_out   (ctl_c[k+1])
        );
    end

    // gain compensation and output register
    cpc_post #(
        .DW (DATA_WIDTH),
        .XW (XW),
        .ZW (ZW)
    ) u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_c[N]),
        .in_ready  (ready_c[N]),
        .x_in      (x_c[N]),
        .y_in      (y_c[N]),
        .z_in      (z_c[N]),
        .ctl_in    (ctl_c[N]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result_a  (result_a),
        .result_b  (result_b)
    );

    // pack result transfer
    assign m_axis_tdata = OUT_TW'({result_b, result_a});

endmodule

`default_nettype wire

>>> rtl/core/cpc_prep.sv
// Input conditioning stage: quadrant folding, angle wrapping and guard-bit scaling.
// Depends on cpc_pkg.
`default_nettype none

module cpc_prep #(
    parameter int DW = cpc_pkg::DATA_WIDTH_DEF,
    parameter int XW = DW + 10,
    parameter int ZW = 28
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire                        opcode,
    input  wire  signed [DW-1:0]       coord_a,
    input  wire  signed [DW-1:0]       coord_b,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [XW-1:0]       x_out,
    output logic signed [XW-1:0]       y_out,
    output logic signed [ZW-1:0]       z_out,
    output cpc_pkg::cpc_ctl_t          ctl_out
);

    localparam logic signed [ZW-1:0] D90  = ZW'(cpc_pkg::DEG90_IN);
    localparam logic signed [ZW-1:0] D180 = ZW'(cpc_pkg::DEG180_IN);
    localparam logic signed [ZW-1:0] D360 = ZW'(cpc_pkg::DEG360_IN);

    logic                       valid_reg, valid_next;
    logic signed [XW-1:0]       x_reg, x_next;
    logic signed [XW-1:0]       y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    cpc_pkg::cpc_ctl_t          ctl_reg, ctl_next;

    logic signed [XW-1:0]       ax, bx;
    logic signed [ZW-1:0]       bz, t_wrap, t_fold;
    logic signed [DW:0]         r_ext, r_fold;
    logic                       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // operand setup for both modes
    always_comb begin
        ax     = XW'(coord_a) <<< cpc_pkg::GUARD_BITS;
        bx     = XW'(coord_b) <<< cpc_pkg::GUARD_BITS;
        bz     = ZW'(coord_b);
        r_ext  = (DW+1)'(coord_a);
        r_fold = r_ext;

        // wrap angle into +-180, then fold into +-90 with a negated radius
        if (bz > D180) begin
            t_wrap = bz - D360;
        end else if (bz < -D180) begin
            t_wrap = bz + D360;
        end else begin
            t_wrap = bz;
        end
        t_fold = t_wrap;
        if (t_wrap > D90) begin
            t_fold = t_wrap - D180;
            r_fold = -r_ext;
        end else if (t_wrap < -D90) begin
            t_fold = t_wrap + D180;
            r_fold = -r_ext;
        end

        ctl_next.rot    = (opcode == cpc_pkg::OP_TO_RECT);
        ctl_next.origin = (coord_a == '0) && (coord_b == '0);

        if (opcode == cpc_pkg::OP_TO_RECT) begin
            x_next = XW'(r_fold) <<< cpc_pkg::GUARD_BITS;
            y_next = '0;
            z_next = t_fold <<< cpc_pkg::ANGLE_SHIFT;
        end else if (coord_a[DW-1]) begin
            // left half plane: negate the vector, start from +-180 degrees
            x_next = -ax;
            y_next = -bx;
            z_next = coord_b[DW-1] ? -(D180 <<< cpc_pkg::ANGLE_SHIFT)
                                   : (D180 <<< cpc_pkg::ANGLE_SHIFT);
        end else begin
            x_next = ax;
            y_next = bx;
            z_next = '0;
        end
    end

    // stage valid
    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign ctl_out   = ctl_reg;

endmodule

`default_nettype wire

>>> rtl/core/cpc_cell.sv
// One CORDIC micro-rotation cell with its own pipeline register and handshake.
// Depends on cpc_pkg for the arctangent table and control struct.
`default_nettype none

module cpc_cell #(
    parameter int XW  = 26,
    parameter int ZW  = 28,
    parameter int IDX = 0
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  signed [XW-1:0]       x_in,
    input  wire  signed [XW-1:0]       y_in,
    input  wire  signed [ZW-1:0]       z_in,
    input  cpc_pkg::cpc_ctl_t          ctl_in,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [XW-1:0]       x_out,
    output logic signed [XW-1:0]       y_out,
    output logic signed [ZW-1:0]       z_out,
    output cpc_pkg::cpc_ctl_t          ctl_out
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(cpc_pkg::atan_q16(IDX));

    logic                       valid_reg, valid_next;
    logic signed [XW-1:0]       x_reg, x_next;
    logic signed [XW-1:0]       y_reg, y_next;
    logic signed [ZW-1:0]       z_reg, z_next;
    cpc_pkg::cpc_ctl_t          ctl_reg;

    logic signed [XW-1:0]       xs, ys;
    logic                       turn_neg;
    logic                       load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // direction: rotation follows the residual angle, vectoring drives y to zero
    always_comb begin
        turn_neg = ctl_in.rot ? !z_in[ZW-1] : y_in[XW-1];
        xs       = x_in >>> IDX;
        ys       = y_in >>> IDX;
        if (turn_neg) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= ctl_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign ctl_out   = ctl_reg;

endmodule

`default_nettype wire

>>> rtl/core/cpc_post.sv
// Gain compensation and saturation: a multiply stage followed by the output register.
// Depends on cpc_pkg.
`default_nettype none

module cpc_post #(
    parameter int DW = cpc_pkg::DATA_WIDTH_DEF,
    parameter int XW = DW + 10,
    parameter int ZW = 28
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  signed [XW-1:0]       x_in,
    input  wire  signed [XW-1:0]       y_in,
    input  wire  signed [ZW-1:0]       z_in,
    input  cpc_pkg::cpc_ctl_t          ctl_in,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic signed [DW:0]         result_a,
    output logic signed [DW-1:0]       result_b
);

    localparam int PW    = XW + 17;
    localparam int SHIFT = cpc_pkg::GAIN_SHIFT + cpc_pkg::GUARD_BITS;
    localparam int RAW   = PW - SHIFT;
    localparam int BW    = ZW - cpc_pkg::ANGLE_SHIFT;

    localparam logic signed [PW-1:0]  GAIN   = PW'(cpc_pkg::GAIN_Q16);
    localparam logic signed [RAW-1:0] RA_MAX = RAW'({DW{1'b1}});
    localparam logic signed [RAW-1:0] RA_MIN = ~RA_MAX;
    localparam logic signed [BW-1:0]  RB_MAX = BW'({(DW-1){1'b1}});
    localparam logic signed [BW-1:0]  RB_MIN = ~RB_MAX;

    logic                       mul_valid_reg, mul_valid_next;
    logic signed [PW-1:0]       prod_a_reg, prod_a_next;
    logic signed [PW-1:0]       prod_b_reg, prod_b_next;
    logic signed [BW-1:0]       zq_reg, zq_next;
    cpc_pkg::cpc_ctl_t          ctl_reg;

    logic                       res_valid_reg, res_valid_next;
    logic signed [DW:0]         result_a_reg, result_a_next;
    logic signed [DW-1:0]       result_b_reg, result_b_next;

    logic signed [PW-1:0]       xe, ye, sh_a, sh_b;
    logic signed [ZW-1:0]       sh_z;
    logic signed [RAW-1:0]      qa, qb;
    logic signed [BW-1:0]       bsel;
    logic                       res_ready, mul_ready, mul_load, res_load;

    // handshake of the two stages
    assign res_ready = !res_valid_reg || out_ready;
    assign mul_ready = !mul_valid_reg || res_ready;
    assign in_ready  = mul_ready;
    assign mul_load  = in_valid && mul_ready;
    assign res_load  = mul_valid_reg && res_ready;

    // gain multiply and angle scaling
    always_comb begin
        xe          = PW'(x_in);
        ye          = PW'(y_in);
        prod_a_next = xe * GAIN;
        prod_b_next = ye * GAIN;
        sh_z        = z_in >>> cpc_pkg::ANGLE_SHIFT;
        zq_next     = sh_z[BW-1:0];
    end

    // truncate, select and saturate
    always_comb begin
        sh_a = prod_a_reg >>> SHIFT;
        sh_b = prod_b_reg >>> SHIFT;
        qa   = sh_a[RAW-1:0];
        qb   = sh_b[RAW-1:0];
        if (ctl_reg.rot) begin
            bsel = BW'(qb);
        end else if (ctl_reg.origin) begin
            bsel = '0;
        end else begin
            bsel = zq_reg;
        end

        if (qa > RA_MAX) begin
            result_a_next = RA_MAX[DW:0];
        end else if (qa < RA_MIN) begin
            result_a_next = RA_MIN[DW:0];
        end else begin
            result_a_next = qa[DW:0];
        end

        if (bsel > RB_MAX) begin
            result_b_next = RB_MAX[DW-1:0];
        end else if (bsel < RB_MIN) begin
            result_b_next = RB_MIN[DW-1:0];
        end else begin
            result_b_next = bsel[DW-1:0];
        end
    end

    always_comb begin
        mul_valid_next = mul_ready ? in_valid : mul_valid_reg;
        res_valid_next = res_ready ? mul_valid_reg : res_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_load) begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            zq_reg     <= zq_next;
            ctl_reg    <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            result_a_reg <= result_a_next;
            result_b_reg <= result_b_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign result_a  = result_a_reg;
    assign result_b  = result_b_reg;

endmodule

`default_nettype wire
